>>> design/pgae_pkg.sv
// Shared constants, types and widths for the playback gain and echo reference block.
package pgae_pkg;

	localparam int BLOCK_SAMPLES = 480;
	localparam int DELAY_BLOCKS  = 3;
	localparam int LINE_DEPTH    = BLOCK_SAMPLES * DELAY_BLOCKS;
	localparam int PTR_W         = $clog2(LINE_DEPTH);
	localparam int SLOT_W        = $clog2(BLOCK_SAMPLES);
	localparam int CNT_W         = $clog2(BLOCK_SAMPLES + 1);

	localparam int SAMPLE_W    = 16;
	localparam int GAIN_W      = 11;
	localparam int THRESH_W    = 15;
	localparam int IDLE_W      = 14;
	localparam int STAT_W      = 32;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 15;
	localparam int GAIN_SHIFT  = 10;

	localparam logic [GAIN_W-1:0]   GAIN_RESET   = GAIN_W'(512);
	localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(32);
	localparam logic [IDLE_W-1:0]   IDLE_RESET   = IDLE_W'(1000);
	localparam logic [IDLE_W-1:0]   IDLE_GATE    = IDLE_W'(500);
	localparam logic [IDLE_W-1:0]   IDLE_CAP     = IDLE_W'(10000);
	localparam int                  BLOCK_MS     = 10;

	localparam logic [CFG_INDEX_W-1:0] REG_VOLUME_GAIN       = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_AUDIBLE_THRESHOLD = CFG_INDEX_W'(1);

	typedef struct packed {
		logic [IDLE_W-1:0] idle_ms;
		logic [STAT_W-1:0] underrun_count;
		logic [STAT_W-1:0] silence_total_ms;
		logic [STAT_W-1:0] longest_gap_ms;
		logic [STAT_W-1:0] audible_total_ms;
		logic [STAT_W-1:0] played_count;
	} stats_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] speaker_sample;
		logic signed [SAMPLE_W-1:0] mic_out;
		logic signed [SAMPLE_W-1:0] echo_reference;
		logic                       block_end;
		stats_t                     stats;
	} result_t;

endpackage

>>> design/pgae_gain.sv
// Playback gain: sample times gain over 1024, truncated toward zero and saturated.
module pgae_gain
	import pgae_pkg::*;
(
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                       present,
	input  logic        [GAIN_W-1:0]   gain,
	output logic signed [SAMPLE_W-1:0] scaled
);

	localparam int PROD_W = SAMPLE_W + GAIN_W + 1;
	localparam int QUOT_W = PROD_W - GAIN_SHIFT;

	logic signed [SAMPLE_W-1:0] sample_eff;
	logic signed [PROD_W-1:0]   prod;
	logic signed [PROD_W-1:0]   biased;
	logic signed [QUOT_W-1:0]   quot;

	localparam logic signed [QUOT_W-1:0] SAT_MAX = QUOT_W'((1 << (SAMPLE_W - 1)) - 1);
	localparam logic signed [QUOT_W-1:0] SAT_MIN = -QUOT_W'(1 << (SAMPLE_W - 1));

	always_comb begin
		sample_eff = present ? sample : '0;
		prod       = PROD_W'(sample_eff) * $signed({1'b0, gain});
		// round toward zero for negative products
		biased     = prod[PROD_W-1] ? prod + PROD_W'((1 << GAIN_SHIFT) - 1) : prod;
		quot       = QUOT_W'(biased >>> GAIN_SHIFT);
		if (quot > SAT_MAX) begin
			scaled = SAT_MAX[SAMPLE_W-1:0];
		end else if (quot < SAT_MIN) begin
			scaled = SAT_MIN[SAMPLE_W-1:0];
		end else begin
			scaled = quot[SAMPLE_W-1:0];
		end
	end

endmodule

>>> design/pgae_line.sv
// Echo reference delay line: one memory read and write at the same entry per transfer.
module pgae_line
	import pgae_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic signed [SAMPLE_W-1:0] wr_data,
	output logic signed [SAMPLE_W-1:0] echo
);

	logic signed [SAMPLE_W-1:0] mem [LINE_DEPTH];
	logic signed [SAMPLE_W-1:0] rd_data_s1;
	logic [PTR_W-1:0]           ptr_q;
	logic                       filled_q;
	logic                       filled_s1;
	logic                       wrap;

	assign wrap = ptr_q == PTR_W'(LINE_DEPTH - 1);

	// read returns the old entry, then it is replaced
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_data_s1     <= mem[ptr_q];
			mem[ptr_q]     <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q     <= '0;
			filled_q  <= 1'b0;
			filled_s1 <= 1'b0;
		end else if (accept) begin
			ptr_q     <= wrap ? '0 : ptr_q + 1'b1;
			filled_s1 <= filled_q;
			if (wrap) begin
				filled_q <= 1'b1;
			end
		end
	end

	// entries not yet written since reset read as zero
	assign echo = filled_s1 ? rd_data_s1 : '0;

endmodule

>>> design/pgae_stats.sv
// Block activity statistics: gap, underrun, idle, audible and played counters.
module pgae_stats
	import pgae_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                       present,
	input  logic        [THRESH_W-1:0] threshold,
	output logic                       last,
	output stats_t                     stats_nx
);

	logic [SLOT_W-1:0] slot_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              short_q;
	logic              audible_q;
	logic              gap_open_q;
	logic [STAT_W-1:0] gap_len_q;
	stats_t            stats_q;

	logic                  gap_open_nx;
	logic [STAT_W-1:0]     gap_len_nx;
	logic [STAT_W-1:0]     gap_len_inc;
	logic [SAMPLE_W:0]     ext;
	logic [SAMPLE_W:0]     mag;
	logic                  short_now;
	logic                  audible_now;
	logic [CNT_W-1:0]      cnt_now;

	always_comb begin
		last        = slot_q == SLOT_W'(BLOCK_SAMPLES - 1);
		ext         = {sample[SAMPLE_W-1], sample};
		mag         = ext[SAMPLE_W] ? (SAMPLE_W+1)'(0) - ext : ext;
		short_now   = short_q | ~present;
		audible_now = audible_q | (present & (mag > {2'b00, threshold}));
		cnt_now     = cnt_q + CNT_W'(present);
		gap_len_inc = gap_len_q + STAT_W'(BLOCK_MS);

		stats_nx    = stats_q;
		gap_open_nx = gap_open_q;
		gap_len_nx  = gap_len_q;
		if (last) begin
			if (short_now && stats_q.idle_ms < IDLE_GATE) begin
				if (!gap_open_q) begin
					stats_nx.underrun_count = stats_q.underrun_count + 1'b1;
				end
				gap_open_nx               = 1'b1;
				gap_len_nx                = gap_len_inc;
				stats_nx.silence_total_ms = stats_q.silence_total_ms + STAT_W'(BLOCK_MS);
				if (gap_len_inc > stats_q.longest_gap_ms) begin
					stats_nx.longest_gap_ms = gap_len_inc;
				end
			end else begin
				gap_open_nx = 1'b0;
				gap_len_nx  = '0;
			end
			if (audible_now) begin
				stats_nx.idle_ms          = '0;
				stats_nx.audible_total_ms = stats_q.audible_total_ms + STAT_W'(BLOCK_MS);
			end else if (!short_now && stats_q.idle_ms < IDLE_CAP) begin
				stats_nx.idle_ms = stats_q.idle_ms + IDLE_W'(BLOCK_MS);
			end
			stats_nx.played_count = stats_q.played_count + STAT_W'(cnt_now);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q     <= '0;
			cnt_q      <= '0;
			short_q    <= 1'b0;
			audible_q  <= 1'b0;
			gap_open_q <= 1'b0;
			gap_len_q  <= '0;
			stats_q    <= '{idle_ms: IDLE_RESET, default: '0};
		end else if (accept) begin
			if (last) begin
				slot_q    <= '0;
				cnt_q     <= '0;
				short_q   <= 1'b0;
				audible_q <= 1'b0;
			end else begin
				slot_q    <= slot_q + 1'b1;
				cnt_q     <= cnt_now;
				short_q   <= short_now;
				audible_q <= audible_now;
			end
			gap_open_q <= gap_open_nx;
			gap_len_q  <= gap_len_nx;
			stats_q    <= stats_nx;
		end
	end

endmodule

>>> design/pgae_outq.sv
// Two-entry result queue between the pipeline and the output channel.
module pgae_outq
	import pgae_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	input  logic    pop,
	output logic    not_empty,
	output logic    [1:0] count,
	output result_t head
);

	result_t   entry_q [2];
	logic      wr_q;
	logic      rd_q;
	logic [1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	assign not_empty = count_q != '0;
	assign count     = count_q;
	assign head      = entry_q[rd_q];

endmodule

>>> design/playback_gain_activity_echo_reference_top.sv
// Top level of the playback gain, activity statistics and echo reference block.
// One slot is taken per clock when the output side keeps up; each result is registered in
// stage 1 alongside the registered read of the delay-line memory (1440 x 16,
// read and written at the same entry on every transfer) and then enters a two-entry output
// queue. Up to two results may wait while input is still taken. The delay line needs no
// clearing pass after reset: a fill flag makes the echo reference read zero until the
// line has been written through once. Statistic outputs change only on the slot that
// ends a block. Configuration writes are always ready and are taken at once.
module playback_gain_activity_echo_reference_top
	import pgae_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic        [CFG_INDEX_W-1:0] cfg_index,
	input  logic        [CFG_DATA_W-1:0]  cfg_data,

	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_W-1:0]    playback_sample,
	input  logic                          playback_present,
	input  logic signed [SAMPLE_W-1:0]    mic_sample,

	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_W-1:0]    speaker_sample,
	output logic signed [SAMPLE_W-1:0]    mic_out,
	output logic signed [SAMPLE_W-1:0]    echo_reference,
	output logic                          block_end,
	output logic        [IDLE_W-1:0]      idle_ms,
	output logic        [STAT_W-1:0]      underrun_count,
	output logic        [STAT_W-1:0]      silence_total_ms,
	output logic        [STAT_W-1:0]      longest_gap_ms,
	output logic        [STAT_W-1:0]      audible_total_ms,
	output logic        [STAT_W-1:0]      played_count
);

	logic [GAIN_W-1:0]   gain_q;
	logic [THRESH_W-1:0] thresh_q;

	logic                       accept;
	logic                       pop;
	logic signed [SAMPLE_W-1:0] scaled;
	logic signed [SAMPLE_W-1:0] echo;
	logic                       last;
	stats_t                     stats_nx;

	logic                       valid_s1;
	logic signed [SAMPLE_W-1:0] speaker_s1;
	logic signed [SAMPLE_W-1:0] mic_s1;
	logic                       last_s1;
	stats_t                     stats_s1;

	result_t    push_data;
	result_t    head;
	logic [1:0] q_count;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= GAIN_RESET;
			thresh_q <= THRESH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_VOLUME_GAIN:       gain_q   <= cfg_data[GAIN_W-1:0];
				REG_AUDIBLE_THRESHOLD: thresh_q <= cfg_data[THRESH_W-1:0];
				default: ;
			endcase
		end
	end

	// queue plus stage 1 never holds more than two results
	assign pop      = out_valid && out_ready;
	assign in_ready = (({1'b0, q_count} + 3'(valid_s1)) <= 3'd1) || pop;
	assign accept   = in_valid && in_ready;

	pgae_gain u_gain (
		.sample  (playback_sample),
		.present (playback_present),
		.gain    (gain_q),
		.scaled  (scaled)
	);

	pgae_line u_line (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.wr_data (scaled),
		.echo    (echo)
	);

	pgae_stats u_stats (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.sample    (playback_sample),
		.present   (playback_present),
		.threshold (thresh_q),
		.last      (last),
		.stats_nx  (stats_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			speaker_s1 <= scaled;
			mic_s1     <= mic_sample;
			last_s1    <= last;
			stats_s1   <= stats_nx;
		end
	end

	always_comb begin
		push_data.speaker_sample = speaker_s1;
		push_data.mic_out        = mic_s1;
		push_data.echo_reference = echo;
		push_data.block_end      = last_s1;
		push_data.stats          = stats_s1;
	end

	pgae_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s1),
		.push_data (push_data),
		.pop       (pop),
		.not_empty (out_valid),
		.count     (q_count),
		.head      (head)
	);

	assign speaker_sample   = head.speaker_sample;
	assign mic_out          = head.mic_out;
	assign echo_reference   = head.echo_reference;
	assign block_end        = head.block_end;
	assign idle_ms          = head.stats.idle_ms;
	assign underrun_count   = head.stats.underrun_count;
	assign silence_total_ms = head.stats.silence_total_ms;
	assign longest_gap_ms   = head.stats.longest_gap_ms;
	assign audible_total_ms = head.stats.audible_total_ms;
	assign played_count     = head.stats.played_count;

endmodule

>>> dv/playback_gain_activity_echo_reference_top_tb.sv
// Self-checking testbench for the playback gain, activity statistics and echo reference block.
module playback_gain_activity_echo_reference_top_tb;
	import pgae_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int PCM_MAX     = 32767;
	localparam int PCM_MIN     = -32768;
	localparam int LONG_HOLD   = 120;
	localparam int TOTAL_SLOTS = 4 * BLOCK_SAMPLES;
	localparam int MAX_REPORTS = 40;

	// indexes the block has no register for
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = CFG_INDEX_W'(2);
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = CFG_INDEX_W'(3);

	typedef enum logic [2:0] {BLK_LOUD, BLK_QUIET, BLK_SHORT, BLK_BROKEN, BLK_EMPTY} block_kind_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] pcm;
		logic                       present;
		logic signed [SAMPLE_W-1:0] mic;
	} slot_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic        [CFG_INDEX_W-1:0] cfg_index = '0;
	logic        [CFG_DATA_W-1:0]  cfg_data = '0;

	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic signed [SAMPLE_W-1:0]    playback_sample = '0;
	logic                          playback_present = 1'b0;
	logic signed [SAMPLE_W-1:0]    mic_sample = '0;

	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic signed [SAMPLE_W-1:0]    speaker_sample;
	logic signed [SAMPLE_W-1:0]    mic_out;
	logic signed [SAMPLE_W-1:0]    echo_reference;
	logic                          block_end;
	logic        [IDLE_W-1:0]      idle_ms;
	logic        [STAT_W-1:0]      underrun_count;
	logic        [STAT_W-1:0]      silence_total_ms;
	logic        [STAT_W-1:0]      longest_gap_ms;
	logic        [STAT_W-1:0]      audible_total_ms;
	logic        [STAT_W-1:0]      played_count;

	playback_gain_activity_echo_reference_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.playback_sample(playback_sample),
		.playback_present(playback_present),
		.mic_sample(mic_sample),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.speaker_sample(speaker_sample),
		.mic_out(mic_out),
		.echo_reference(echo_reference),
		.block_end(block_end),
		.idle_ms(idle_ms),
		.underrun_count(underrun_count),
		.silence_total_ms(silence_total_ms),
		.longest_gap_ms(longest_gap_ms),
		.audible_total_ms(audible_total_ms),
		.played_count(played_count)
	);

	// predicted block state and register copies
	logic signed [SAMPLE_W-1:0] echo_line [LINE_DEPTH] = '{default: '0};
	logic [PTR_W-1:0]    line_ptr = '0;
	logic [SLOT_W-1:0]   slot_in_block = '0;
	logic [CNT_W-1:0]    present_in_block = '0;
	logic                block_short = 1'b0;
	logic                block_audible = 1'b0;
	logic                gap_open = 1'b0;
	logic [IDLE_W-1:0]   idle_reg = IDLE_RESET;
	logic [STAT_W-1:0]   gap_len = '0;
	logic [STAT_W-1:0]   underruns = '0;
	logic [STAT_W-1:0]   silence_ms = '0;
	logic [STAT_W-1:0]   longest_ms = '0;
	logic [STAT_W-1:0]   audible_ms = '0;
	logic [STAT_W-1:0]   played = '0;
	logic [GAIN_W-1:0]   gain_reg = GAIN_RESET;
	logic [THRESH_W-1:0] thresh_reg = THRESH_RESET;

	slot_t       slots_to_send [$];
	result_t     predicted_slots [$];
	slot_t       next_slot;
	block_kind_t cur_kind = BLK_LOUD;
	int          short_cut = 0;
	bit          kind_chosen = 1'b0;

	int  slots_queued = 0;
	int  slots_offered = 0;
	int  slots_accepted = 0;
	int  results_seen = 0;
	int  blocks_closed = 0;
	int  cfg_writes = 0;
	int  errors = 0;
	int  tx_gap = 0;
	int  rx_wait = 0;
	bit  tx_burst = 1'b0;
	bit  rx_burst = 1'b0;
	bit  in_took = 1'b0;
	bit  out_took = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("Timed out: %0d slots accepted, %0d results still awaited",
			slots_accepted, predicted_slots.size());
		$display("FAILURE");
		$finish;
	end

	// one slot through gain, delay line and block-end statistics
	function automatic result_t play_slot(slot_t s);
		result_t r;
		int pcm;
		int scaled;
		int mag;
		pcm = s.present ? int'(s.pcm) : 0;
		if (s.present) begin
			present_in_block++;
			mag = (pcm < 0) ? -pcm : pcm;
			if (mag > int'(thresh_reg))
				block_audible = 1'b1;
		end else begin
			block_short = 1'b1;
		end
		scaled = (pcm * int'(gain_reg)) / (1 << GAIN_SHIFT);
		if (scaled > PCM_MAX)
			scaled = PCM_MAX;
		else if (scaled < PCM_MIN)
			scaled = PCM_MIN;

		r.echo_reference = echo_line[line_ptr];
		echo_line[line_ptr] = SAMPLE_W'(scaled);
		line_ptr = (line_ptr == PTR_W'(LINE_DEPTH - 1)) ? '0 : line_ptr + 1'b1;

		r.block_end = (slot_in_block == SLOT_W'(BLOCK_SAMPLES - 1));
		if (r.block_end) begin
			blocks_closed++;
			slot_in_block = '0;
			if (block_short && idle_reg < IDLE_GATE) begin
				if (!gap_open)
					underruns++;
				gap_open = 1'b1;
				gap_len += BLOCK_MS;
				silence_ms += BLOCK_MS;
				if (gap_len > longest_ms)
					longest_ms = gap_len;
			end else begin
				gap_open = 1'b0;
				gap_len = '0;
			end
			if (block_audible) begin
				idle_reg = '0;
				audible_ms += BLOCK_MS;
			end else if (!block_short && idle_reg < IDLE_CAP) begin
				idle_reg += IDLE_W'(BLOCK_MS);
			end
			played += STAT_W'(present_in_block);
			present_in_block = '0;
			block_short = 1'b0;
			block_audible = 1'b0;
		end else begin
			slot_in_block++;
		end

		r.speaker_sample = SAMPLE_W'(scaled);
		r.mic_out = s.mic;
		r.stats.idle_ms = idle_reg;
		r.stats.underrun_count = underruns;
		r.stats.silence_total_ms = silence_ms;
		r.stats.longest_gap_ms = longest_ms;
		r.stats.audible_total_ms = audible_ms;
		r.stats.played_count = played;
		return r;
	endfunction

	task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("%0t: %s on result %0d, expected %0h, actual %0h",
				$time, what, results_seen, want, got);
	endtask

	task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
		if (got !== want)
			note_mismatch({what, " mismatch"}, want, got);
	endtask

	// transfers are sampled here; prediction is pushed before the output check
	always @(posedge clk) begin
		in_took = 1'b0;
		out_took = 1'b0;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				cfg_writes++;
				case (cfg_index)
					REG_VOLUME_GAIN:       gain_reg = cfg_data[GAIN_W-1:0];
					REG_AUDIBLE_THRESHOLD: thresh_reg = cfg_data[THRESH_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				in_took = 1'b1;
				slots_accepted++;
				predicted_slots.push_back(play_slot({playback_sample, playback_present,
					mic_sample}));
			end
			if (out_valid && out_ready) begin
				result_t want;
				out_took = 1'b1;
				results_seen++;
				if (predicted_slots.size() == 0) begin
					note_mismatch("result with none awaited", '0, 32'(speaker_sample));
				end else begin
					want = predicted_slots.pop_front();
					check_field("speaker_sample", 32'(want.speaker_sample),
						32'(speaker_sample));
					check_field("mic_out", 32'(want.mic_out), 32'(mic_out));
					check_field("echo_reference", 32'(want.echo_reference),
						32'(echo_reference));
					check_field("block_end", 32'(want.block_end), 32'(block_end));
					check_field("idle_ms", 32'(want.stats.idle_ms), 32'(idle_ms));
					check_field("underrun_count", want.stats.underrun_count, underrun_count);
					check_field("silence_total_ms", want.stats.silence_total_ms,
						silence_total_ms);
					check_field("longest_gap_ms", want.stats.longest_gap_ms, longest_gap_ms);
					check_field("audible_total_ms", want.stats.audible_total_ms,
						audible_total_ms);
					check_field("played_count", want.stats.played_count, played_count);
				end
			end
		end
	end

	// sender: holds each slot until its transfer, then waits its drawn gap
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_took)) begin
			if (tx_gap != 0) begin
				in_valid <= 1'b0;
				tx_gap--;
			end else if (slots_to_send.size() != 0) begin
				next_slot = slots_to_send.pop_front();
				playback_sample <= next_slot.pcm;
				playback_present <= next_slot.present;
				mic_sample <= next_slot.mic;
				in_valid <= 1'b1;
				if (slots_offered % 50 == 0)
					tx_burst = ($urandom_range(0, 3) == 0);
				slots_offered++;
				tx_gap = tx_burst ? 0 : $urandom_range(0, 10);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: random stall after each result, two long holds to back up the block
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_took) begin
				if (results_seen % 50 == 0)
					rx_burst = ($urandom_range(0, 3) == 0);
				rx_wait = rx_burst ? 0 : $urandom_range(0, 10);
				if (results_seen == 600 || results_seen == 1400)
					rx_wait = LONG_HOLD;
			end
			if (rx_wait != 0) begin
				out_ready <= 1'b0;
				rx_wait--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	function automatic logic signed [SAMPLE_W-1:0] rand_pcm();
		case ($urandom_range(0, 9))
			0:       return SAMPLE_W'(PCM_MAX);
			1:       return SAMPLE_W'(PCM_MIN);
			2:       return '0;
			3:       return '1;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	task automatic push_slot(logic signed [SAMPLE_W-1:0] pcm, logic present,
			logic signed [SAMPLE_W-1:0] mic);
		slots_to_send.push_back({pcm, present, mic});
		slots_queued++;
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// wait until every slot is sent and every result is back
	task automatic settle();
		do @(posedge clk);
		while (slots_to_send.size() != 0 || in_valid || predicted_slots.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// whole blocks of one kind; short blocks are a received run then padding
	task automatic queue_slots(int target);
		int pos;
		int thr;
		int pick;
		logic signed [SAMPLE_W-1:0] pcm;
		while (slots_queued < target) begin
			pos = slots_queued % BLOCK_SAMPLES;
			if (pos == 0 || !kind_chosen) begin
				kind_chosen = 1'b1;
				pick = $urandom_range(0, 99);
				if (pick < 35)
					cur_kind = BLK_SHORT;
				else if (pick < 60)
					cur_kind = BLK_LOUD;
				else if (pick < 75)
					cur_kind = BLK_QUIET;
				else if (pick < 90)
					cur_kind = BLK_BROKEN;
				else
					cur_kind = BLK_EMPTY;
				short_cut = $urandom_range(1, BLOCK_SAMPLES - 1);
			end
			pcm = rand_pcm();
			case (cur_kind)
				BLK_LOUD:   push_slot(pcm, 1'b1, rand_pcm());
				BLK_QUIET: begin
					thr = int'(thresh_reg);
					if ($urandom_range(0, 7) == 0)
						pcm = $urandom_range(0, 1) ? SAMPLE_W'(thr) : SAMPLE_W'(-thr);
					else
						pcm = SAMPLE_W'(int'($urandom_range(0, 2 * thr)) - thr);
					push_slot(pcm, 1'b1, rand_pcm());
				end
				BLK_SHORT:  push_slot(pcm, pos < short_cut, rand_pcm());
				BLK_BROKEN: push_slot(pcm, 1'(($urandom_range(0, 1))), rand_pcm());
				default:    push_slot(pcm, 1'b0, rand_pcm());
			endcase
		end
	endtask

	initial begin
		int target;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset gain and threshold: extremes, truncation toward zero, padding then received
		push_slot(16'sh7FFF, 1'b1, 16'sh8000);
		push_slot(16'sh8000, 1'b1, 16'sh7FFF);
		push_slot(16'sh0000, 1'b1, 16'sh0000);
		push_slot(16'shFFFF, 1'b1, 16'shFFFF);
		push_slot(16'sh0001, 1'b1, 16'sh0001);
		push_slot(16'sh0020, 1'b1, 16'sh2AAA);
		push_slot(16'sh1234, 1'b0, 16'sh5555);
		push_slot(16'shFFFD, 1'b1, 16'shAAAA);
		settle();

		// gain above unity saturates; upper data bits must be dropped
		write_reg(REG_VOLUME_GAIN, 15'h7FFF);
		push_slot(16'sh7FFF, 1'b1, 16'sh0F0F);
		push_slot(16'sh8000, 1'b1, 16'shF0F0);
		push_slot(16'sd17000, 1'b1, 16'sh0000);
		push_slot(-16'sd17000, 1'b1, 16'sh0000);
		settle();

		// writes to spare indexes must leave both registers alone
		write_reg(REG_SPARE_2, CFG_DATA_W'($urandom));
		write_reg(REG_SPARE_3, CFG_DATA_W'($urandom));
		write_reg(REG_VOLUME_GAIN, CFG_DATA_W'(1024));
		write_reg(REG_AUDIBLE_THRESHOLD, '0);
		push_slot(16'sh8000, 1'b1, 16'sh0001);
		push_slot(16'sh7FFF, 1'b1, 16'sh0002);
		push_slot(-16'sd7, 1'b1, 16'sh0003);
		push_slot(16'sh7FFF, 1'b0, 16'sh0004);
		settle();

		// zero gain, top threshold: only full-scale negative is above it
		write_reg(REG_VOLUME_GAIN, '0);
		write_reg(REG_AUDIBLE_THRESHOLD, 15'h7FFF);
		push_slot(16'sh7FFF, 1'b1, 16'sh1111);
		push_slot(16'sh8000, 1'b1, 16'sh2222);
		push_slot(16'sh7FFF, 1'b1, 16'sh3333);
		settle();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					write_reg(REG_VOLUME_GAIN, CFG_DATA_W'(GAIN_RESET));
					write_reg(REG_AUDIBLE_THRESHOLD, CFG_DATA_W'(THRESH_RESET));
				end
				1: begin
					write_reg(REG_VOLUME_GAIN, CFG_DATA_W'($urandom_range(1, 1023)));
					write_reg(REG_AUDIBLE_THRESHOLD, CFG_DATA_W'($urandom_range(0, 2000)));
				end
				2: begin
					write_reg(REG_VOLUME_GAIN, {4'($urandom), 11'($urandom_range(1025, 2047))});
					write_reg(REG_AUDIBLE_THRESHOLD, '0);
				end
				3: begin
					write_reg(REG_VOLUME_GAIN, CFG_DATA_W'(1024));
					write_reg(REG_AUDIBLE_THRESHOLD, 15'h7FFF);
				end
				4: begin
					write_reg(REG_VOLUME_GAIN, '0);
					write_reg(REG_AUDIBLE_THRESHOLD, CFG_DATA_W'($urandom));
				end
				default: begin
					write_reg(REG_VOLUME_GAIN, CFG_DATA_W'($urandom));
					write_reg(REG_AUDIBLE_THRESHOLD, CFG_DATA_W'($urandom_range(0, 4000)));
				end
			endcase
			target = (ph == 5) ? TOTAL_SLOTS :
				slots_queued + (TOTAL_SLOTS - slots_queued) / (6 - ph);
			queue_slots(target);
			settle();
		end

		repeat (10) @(posedge clk);
		if (predicted_slots.size() != 0)
			note_mismatch("results never delivered", predicted_slots.size(), '0);

		$display("Covered %0d slots, %0d closed blocks, %0d register writes, %0d line wraps.",
			slots_accepted, blocks_closed, cfg_writes, slots_accepted / LINE_DEPTH);
		$display("Stats: %0d underruns, %0d ms silent, %0d ms gap, %0d ms audible, %0d played.",
			underruns, silence_ms, longest_ms, audible_ms, played);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

>>> sim.f
design/pgae_pkg.sv
design/pgae_gain.sv
design/pgae_line.sv
design/pgae_stats.sv
design/pgae_outq.sv
design/playback_gain_activity_echo_reference_top.sv
dv/playback_gain_activity_echo_reference_top_tb.sv
